>>> rtl/core/efdm_pkg.sv
package efdm_pkg;

   localparam int unsigned TS_W    = 32;
   localparam int unsigned FREQ_W  = 28;
   localparam int unsigned DUTY_W  = 15;
   localparam int unsigned DIV_W   = 48;
   localparam int unsigned STEP_W  = 6;
   localparam int unsigned Q_DEPTH = 2;
   localparam int unsigned Q_CNT_W = 2;

   localparam logic [TS_W-1:0]   MAX32     = 32'hFFFF_FFFF;
   localparam logic [TS_W-1:0]   Q8_MHZ    = 32'd256000000;
   localparam logic [DUTY_W-1:0] DUTY_FULL = 15'd25600;

   typedef enum logic [1:0] {
      KIND_RISE = 2'd0,
      KIND_FALL = 2'd1,
      KIND_TICK = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type        kind;
      logic [TS_W-1:0] ts;
   } cmd_type;

   typedef struct packed {
      logic             start;
      logic             wide;
      logic [DIV_W-1:0] dividend;
      logic [TS_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_AVG,
      B_FREQ,
      B_MUL,
      B_DUTY_GO,
      B_DUTY,
      B_DONE
   } back_state_type;

endpackage

>>> rtl/core/efdm_req_if.sv
interface efdm_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  kind;
   logic [efdm_pkg::TS_W-1:0]   timestamp;

   modport source (output valid, output kind, output timestamp, input ready);
   modport sink   (input valid, input kind, input timestamp, output ready);
endinterface

>>> rtl/core/efdm_rsp_if.sv
interface efdm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [efdm_pkg::FREQ_W-1:0]  frequency_q8;
   logic [efdm_pkg::DUTY_W-1:0]  duty_q8;
   logic [efdm_pkg::TS_W-1:0]    last_period;
   logic [efdm_pkg::TS_W-1:0]    last_high;
   logic [efdm_pkg::TS_W-1:0]    last_low;
   logic [efdm_pkg::TS_W-1:0]    cycles_in_window;

   modport source (output valid, output frequency_q8, output duty_q8, output last_period,
                   output last_high, output last_low, output cycles_in_window, input ready);
   modport sink   (input valid, input frequency_q8, input duty_q8, input last_period,
                   input last_high, input last_low, input cycles_in_window, output ready);
endinterface

>>> rtl/core/edge_frequency_duty_meter_unit.sv
// Edge frequency and duty meter.
// req_bus: one beat per event; kind 0 rising edge, 1 falling edge, 2 window tick,
//   with a 32-bit microsecond timestamp (wrapping). Kind 3 beats are taken and dropped.
// rsp_bus: one beat per window tick that follows at least one complete period:
//   frequency (Q8 Hz), duty (Q8 percent), last period/high/low and cycle count.
// A 2-entry queue sits between the intake and the execution side; each edge is
//   executed as it is popped, so edge beats stream at one per cycle while no
//   report is in progress. A reporting tick runs up to three divisions on one
//   shared radix-2 divider: average period (32 steps), frequency (32 steps) and
//   duty (48 steps); the intake keeps queueing meanwhile until the queue fills.
//   A tick with nothing to report is taken without leaving the idle state.
// The result waits in an output register while rsp_bus.ready is low; edges keep
//   executing behind it, and a second report waits for the register to empty.
// Synchronous reset clears all timestamps, spans, window totals and flags, and
//   empties the queue and output register; req_bus.ready is high the cycle after.
module edge_frequency_duty_meter_unit (
   input  logic       clock,
   input  logic       reset,
   efdm_req_if.sink   req_bus,
   efdm_rsp_if.source rsp_bus
);

   logic                  push_valid;
   efdm_pkg::cmd_type     push_cmd;
   logic                  q_full;
   logic                  pop_valid;
   logic                  pop_ready;
   efdm_pkg::cmd_type     pop_cmd;
   efdm_pkg::div_req_type div_req;
   efdm_pkg::div_rsp_type div_rsp;

   efdm_front u_front (
      .req        (req_bus),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   efdm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   efdm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   efdm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp       (rsp_bus)
   );

endmodule

>>> rtl/core/efdm_front.sv
module efdm_front (
   efdm_req_if.sink          req,
   input  logic              q_full,
   output logic              push_valid,
   output efdm_pkg::cmd_type push_cmd
);

   logic known;

   always_comb begin
      known = 1'b1;
      push_cmd.ts = req.timestamp;
      unique case (req.kind)
         efdm_pkg::KIND_RISE: push_cmd.kind = efdm_pkg::KIND_RISE;
         efdm_pkg::KIND_FALL: push_cmd.kind = efdm_pkg::KIND_FALL;
         efdm_pkg::KIND_TICK: push_cmd.kind = efdm_pkg::KIND_TICK;
         default: begin
            push_cmd.kind = efdm_pkg::KIND_TICK;
            known = 1'b0;
         end
      endcase
   end

   // unused kind is taken and dropped
   assign req.ready  = !q_full;
   assign push_valid = req.valid && !q_full && known;

endmodule

>>> rtl/core/efdm_queue.sv
module efdm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  efdm_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              pop_valid,
   input  logic              pop_ready,
   output efdm_pkg::cmd_type pop_cmd
);

   efdm_pkg::cmd_type entry_ff [efdm_pkg::Q_DEPTH];
   logic                          wr_ptr_ff, wr_ptr_in;
   logic                          rd_ptr_ff, rd_ptr_in;
   logic [efdm_pkg::Q_CNT_W-1:0]  count_ff, count_in;
   logic                          do_push, do_pop;

   assign full      = (count_ff == efdm_pkg::Q_CNT_W'(efdm_pkg::Q_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/efdm_div.sv
module efdm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  efdm_pkg::div_req_type div_req,
   output efdm_pkg::div_rsp_type div_rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [efdm_pkg::STEP_W-1:0]  cnt_ff, cnt_in;
   logic [efdm_pkg::TS_W:0]      rem_ff, rem_in;
   logic [efdm_pkg::DIV_W-1:0]   q_ff, q_in;
   logic [efdm_pkg::TS_W-1:0]    dvs_ff, dvs_in;
   logic [efdm_pkg::TS_W:0]      rem_shift;
   logic [efdm_pkg::TS_W+1:0]    diff;

   assign rem_shift = {rem_ff[efdm_pkg::TS_W-1:0], q_ff[efdm_pkg::DIV_W-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         if (div_req.wide) begin
            q_in   = div_req.dividend;
            cnt_in = efdm_pkg::STEP_W'(efdm_pkg::DIV_W);
         end else begin
            // left-justify a 32-bit dividend
            q_in   = {div_req.dividend[efdm_pkg::TS_W-1:0],
                      (efdm_pkg::DIV_W - efdm_pkg::TS_W)'(0)};
            cnt_in = efdm_pkg::STEP_W'(efdm_pkg::TS_W);
         end
      end else if (busy_ff) begin
         if (!diff[efdm_pkg::TS_W+1]) begin
            rem_in = diff[efdm_pkg::TS_W:0];
            q_in   = {q_ff[efdm_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            q_in   = {q_ff[efdm_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == efdm_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      q_ff   <= q_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q_ff;

endmodule

>>> rtl/core/efdm_back.sv
module efdm_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   output logic                  cmd_ready,
   input  efdm_pkg::cmd_type     cmd,
   output efdm_pkg::div_req_type div_req,
   input  efdm_pkg::div_rsp_type div_rsp,
   efdm_rsp_if.source            rsp
);

   localparam int unsigned TW = efdm_pkg::TS_W;
   localparam int unsigned MW = TW + efdm_pkg::DUTY_W;

   efdm_pkg::back_state_type state_ff, state_in;

   logic [TW-1:0] rise_time_ff, rise_time_in;
   logic [TW-1:0] fall_time_ff, fall_time_in;
   logic          rise_seen_ff, rise_seen_in;
   logic          fall_seen_ff, fall_seen_in;
   logic [TW-1:0] high_span_ff, high_span_in;
   logic [TW-1:0] low_span_ff, low_span_in;
   logic [TW-1:0] period_span_ff, period_span_in;
   logic [TW-1:0] total_ff, total_in;
   logic [TW-1:0] count_ff, count_in;
   logic          complete_ff, complete_in;

   logic [TW-1:0]                 j_per_ff, j_per_in;
   logic [TW-1:0]                 j_high_ff, j_high_in;
   logic [TW-1:0]                 j_low_ff, j_low_in;
   logic [TW-1:0]                 j_count_ff, j_count_in;
   logic [efdm_pkg::FREQ_W-1:0]   freq_ff, freq_in;
   logic [efdm_pkg::DUTY_W-1:0]   duty_ff, duty_in;
   logic [efdm_pkg::DIV_W-1:0]    prod_ff, prod_in;

   logic                          out_valid_ff, out_valid_in;
   logic [efdm_pkg::FREQ_W-1:0]   o_freq_ff, o_freq_in;
   logic [efdm_pkg::DUTY_W-1:0]   o_duty_ff, o_duty_in;
   logic [TW-1:0]                 o_per_ff, o_per_in;
   logic [TW-1:0]                 o_high_ff, o_high_in;
   logic [TW-1:0]                 o_low_ff, o_low_in;
   logic [TW-1:0]                 o_count_ff, o_count_in;

   logic [TW-1:0] per_now;
   logic [TW:0]   sum;
   logic [TW-1:0] avg;
   logic [MW-1:0] mul;

   assign per_now = cmd.ts - rise_time_ff;
   assign sum     = {1'b0, total_ff} + {1'b0, per_now};
   assign avg     = div_rsp.quotient[TW-1:0];
   assign mul     = j_high_ff * efdm_pkg::DUTY_FULL;

   always_comb begin
      state_in       = state_ff;
      rise_time_in   = rise_time_ff;
      fall_time_in   = fall_time_ff;
      rise_seen_in   = rise_seen_ff;
      fall_seen_in   = fall_seen_ff;
      high_span_in   = high_span_ff;
      low_span_in    = low_span_ff;
      period_span_in = period_span_ff;
      total_in       = total_ff;
      count_in       = count_ff;
      complete_in    = complete_ff;
      j_per_in       = j_per_ff;
      j_high_in      = j_high_ff;
      j_low_in       = j_low_ff;
      j_count_in     = j_count_ff;
      freq_in        = freq_ff;
      duty_in        = duty_ff;
      prod_in        = prod_ff;
      out_valid_in   = out_valid_ff && !rsp.ready;
      o_freq_in      = o_freq_ff;
      o_duty_in      = o_duty_ff;
      o_per_in       = o_per_ff;
      o_high_in      = o_high_ff;
      o_low_in       = o_low_ff;
      o_count_in     = o_count_ff;
      cmd_ready      = 1'b0;
      div_req        = '0;

      unique case (state_ff)
         efdm_pkg::B_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               unique case (cmd.kind)
                  efdm_pkg::KIND_RISE: begin
                     if (fall_seen_ff) begin
                        low_span_in = cmd.ts - fall_time_ff;
                     end
                     if (rise_seen_ff) begin
                        period_span_in = per_now;
                        total_in       = sum[TW] ? efdm_pkg::MAX32 : sum[TW-1:0];
                        if (count_ff != efdm_pkg::MAX32) begin
                           count_in = count_ff + 1'b1;
                        end
                        complete_in = 1'b1;
                     end
                     rise_time_in = cmd.ts;
                     rise_seen_in = 1'b1;
                  end
                  efdm_pkg::KIND_FALL: begin
                     if (rise_seen_ff) begin
                        high_span_in = per_now;
                     end
                     fall_time_in = cmd.ts;
                     fall_seen_in = 1'b1;
                  end
                  efdm_pkg::KIND_TICK: begin
                     if (complete_ff) begin
                        div_req.start    = 1'b1;
                        div_req.wide     = 1'b0;
                        div_req.dividend = efdm_pkg::DIV_W'(total_ff);
                        div_req.divisor  = count_ff;
                        j_per_in         = period_span_ff;
                        j_high_in        = high_span_ff;
                        j_low_in         = low_span_ff;
                        j_count_in       = count_ff;
                        total_in         = '0;
                        count_in         = '0;
                        complete_in      = 1'b0;
                        state_in         = efdm_pkg::B_AVG;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         efdm_pkg::B_AVG: begin
            if (div_rsp.done) begin
               if (avg == '0) begin
                  freq_in  = '0;
                  state_in = efdm_pkg::B_MUL;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.wide     = 1'b0;
                  // round half up
                  div_req.dividend = efdm_pkg::DIV_W'(efdm_pkg::Q8_MHZ + {1'b0, avg[TW-1:1]});
                  div_req.divisor  = avg;
                  state_in         = efdm_pkg::B_FREQ;
               end
            end
         end
         efdm_pkg::B_FREQ: begin
            if (div_rsp.done) begin
               freq_in  = div_rsp.quotient[efdm_pkg::FREQ_W-1:0];
               state_in = efdm_pkg::B_MUL;
            end
         end
         efdm_pkg::B_MUL: begin
            prod_in  = efdm_pkg::DIV_W'(mul) + efdm_pkg::DIV_W'(j_per_ff[TW-1:1]);
            state_in = efdm_pkg::B_DUTY_GO;
         end
         efdm_pkg::B_DUTY_GO: begin
            if (j_per_ff == '0) begin
               duty_in  = '0;
               state_in = efdm_pkg::B_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.wide     = 1'b1;
               div_req.dividend = prod_ff;
               div_req.divisor  = j_per_ff;
               state_in         = efdm_pkg::B_DUTY;
            end
         end
         efdm_pkg::B_DUTY: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient > efdm_pkg::DIV_W'(efdm_pkg::DUTY_FULL)) begin
                  duty_in = efdm_pkg::DUTY_FULL;
               end else begin
                  duty_in = div_rsp.quotient[efdm_pkg::DUTY_W-1:0];
               end
               state_in = efdm_pkg::B_DONE;
            end
         end
         efdm_pkg::B_DONE: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               o_freq_in    = freq_ff;
               o_duty_in    = duty_ff;
               o_per_in     = j_per_ff;
               o_high_in    = j_high_ff;
               o_low_in     = j_low_ff;
               o_count_in   = j_count_ff;
               state_in     = efdm_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = efdm_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= efdm_pkg::B_IDLE;
         rise_time_ff   <= '0;
         fall_time_ff   <= '0;
         rise_seen_ff   <= 1'b0;
         fall_seen_ff   <= 1'b0;
         high_span_ff   <= '0;
         low_span_ff    <= '0;
         period_span_ff <= '0;
         total_ff       <= '0;
         count_ff       <= '0;
         complete_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rise_time_ff   <= rise_time_in;
         fall_time_ff   <= fall_time_in;
         rise_seen_ff   <= rise_seen_in;
         fall_seen_ff   <= fall_seen_in;
         high_span_ff   <= high_span_in;
         low_span_ff    <= low_span_in;
         period_span_ff <= period_span_in;
         total_ff       <= total_in;
         count_ff       <= count_in;
         complete_ff    <= complete_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      j_per_ff   <= j_per_in;
      j_high_ff  <= j_high_in;
      j_low_ff   <= j_low_in;
      j_count_ff <= j_count_in;
      freq_ff    <= freq_in;
      duty_ff    <= duty_in;
      prod_ff    <= prod_in;
      o_freq_ff  <= o_freq_in;
      o_duty_ff  <= o_duty_in;
      o_per_ff   <= o_per_in;
      o_high_ff  <= o_high_in;
      o_low_ff   <= o_low_in;
      o_count_ff <= o_count_in;
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.frequency_q8     = o_freq_ff;
   assign rsp.duty_q8          = o_duty_ff;
   assign rsp.last_period      = o_per_ff;
   assign rsp.last_high        = o_high_ff;
   assign rsp.last_low         = o_low_ff;
   assign rsp.cycles_in_window = o_count_ff;

endmodule

>>> rtl/core/efdm_checker.sv
module efdm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [efdm_pkg::FREQ_W-1:0] rsp_frequency_q8,
   input logic [efdm_pkg::DUTY_W-1:0] rsp_duty_q8,
   input logic [efdm_pkg::TS_W-1:0]   rsp_cycles_in_window
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_duty_q8) && $stable(rsp_frequency_q8))
      else $error("rsp payload changed while stalled");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_q8 <= efdm_pkg::DUTY_FULL)
      else $error("duty above full scale");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cycles_in_window != '0)
      else $error("report with no complete cycle");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind edge_frequency_duty_meter_unit efdm_checker u_efdm_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_frequency_q8     (rsp_bus.frequency_q8),
   .rsp_duty_q8          (rsp_bus.duty_q8),
   .rsp_cycles_in_window (rsp_bus.cycles_in_window)
);
